>>> rtl/hcpe_pkg.sv
// Shared types and constants of the hue curve point extractor.
// Used by every file in rtl/; depends on nothing else.
package hcpe_pkg;

	// Payload field widths.
	localparam int unsigned HUE_W = 8;
	localparam int unsigned ROW_W = 12;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned X_W   = 13;
	localparam int unsigned Y_W   = 12;

	// Accumulator widths and saturation limits.
	localparam int unsigned SUM_W = 24;
	localparam int unsigned CNT_W = 13;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Hit band half-width around the target hue (exclusive).
	localparam logic [HUE_W:0] HUE_BAND = 9'd5;

	// Division of the segment length by 10 and by 20: multiply by
	// 3277/2^15 and take the upper bits. Exact for all 13-bit lengths.
	localparam int unsigned RECIP_W    = 12;
	localparam int unsigned PROD_W     = LEN_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_10 = 12'd3277;
	localparam int unsigned STEP_SHIFT = 15;
	localparam int unsigned HALF_SHIFT = 16;
	localparam int unsigned STEP_W     = PROD_W - STEP_SHIFT;
	localparam int unsigned HALF_W     = PROD_W - HALF_SHIFT;

	// Shared divider: 24-bit dividend, 13-bit divisor.
	localparam int unsigned DIV_W = SUM_W;
	localparam int unsigned DVS_W = CNT_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

	// Configuration port.
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam logic [1:0] REG_TARGET_HUE = 2'd0;
	localparam logic [1:0] REG_SEG_LEN    = 2'd1;
	localparam logic [1:0] REG_IMG_WIDTH  = 2'd2;
	localparam logic [LEN_W-1:0] IMG_WIDTH_RST = 13'd640;

	// Default sizes.
	localparam int unsigned DEF_MAX_ROWS = 4096;
	localparam int unsigned DEF_MAX_COLS = 4096;

	typedef struct packed {
		logic [HUE_W-1:0] pixel_hue;
		logic [ROW_W-1:0] row_index;
		logic             column_end;
		logic             image_end;
	} pixel_t;

	typedef struct packed {
		logic [X_W-1:0] point_x;
		logic [Y_W-1:0] point_y;
		logic           has_data;
	} point_t;

	typedef enum logic [1:0] {
		DSEL_COL = 2'd0,
		DSEL_MOD = 2'd1,
		DSEL_SEG = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     accept;
		logic     clear_img;
		logic     div_start;
		div_sel_t div_sel;
		logic     col_close;
		logic     col_add;
		logic     emit;
		logic     advance;
	} hcpe_cmd_t;

	typedef struct packed {
		logic col_hits;
		logic seg_hits;
		logic col_zero;
		logic div_done;
		logic rem_zero;
		logic out_free;
	} hcpe_sts_t;

endpackage

>>> rtl/hcpe_if.sv
// Valid/ready stream interfaces for pixel and point transactions.
// Depends on hcpe_pkg for the payload types.
interface hcpe_pixel_if import hcpe_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hcpe_point_if import hcpe_pkg::*; ();
	logic   valid;
	logic   ready;
	point_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/hue_curve_point_extractor.sv
// Pixels inside a column stream in at one per cycle while the controller is idle. A
// column-end pixel holds input off through close, check, emit and finish, plus up to
// three serial divisions (column mean, step test, segment mean); its point becomes
// valid when the emit step registers it. The sequence is shorter when no point is
// due, and longer while an earlier point still waits at the output.
// Reset (arst_n, asynchronous): clears state and output; config 0, 0 and width 640.
module hue_curve_point_extractor import hcpe_pkg::*; #(
	parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	hcpe_pixel_if.sink        pixels,
	hcpe_point_if.source      points
);

	// Configuration registers. Each sits at byte address 4*index; the low two
	// address bits are ignored. A write lands on the access phase.
	logic [HUE_W-1:0] target_hue_q;
	logic [LEN_W-1:0] seg_len_q;
	logic [LEN_W-1:0] img_width_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_hue_q <= '0;
			seg_len_q    <= '0;
			img_width_q  <= IMG_WIDTH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TARGET_HUE: target_hue_q <= pwdata[HUE_W-1:0];
				REG_SEG_LEN:    seg_len_q    <= pwdata[LEN_W-1:0];
				REG_IMG_WIDTH:  img_width_q  <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TARGET_HUE: prdata = DATA_W'(target_hue_q);
			REG_SEG_LEN:    prdata = DATA_W'(seg_len_q);
			REG_IMG_WIDTH:  prdata = DATA_W'(img_width_q);
			default:        prdata = '0;
		endcase
	end

	// The controller owns the pixel handshake: it takes a transaction only
	// while idle, and then runs the column-end sequence when the pixel closes
	// its column. The datapath holds all arithmetic state and the result
	// register, so a finished point can wait for its sink while new pixels
	// keep flowing in.
	hcpe_cmd_t cmd;
	hcpe_sts_t sts;

	hcpe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pixels.valid),
		.column_end (pixels.data.column_end),
		.image_end  (pixels.data.image_end),
		.sts        (sts),
		.pix_ready  (pixels.ready),
		.cmd        (cmd)
	);

	hcpe_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.target_hue     (target_hue_q),
		.segment_length (seg_len_q),
		.image_width    (img_width_q),
		.pix            (pixels.data),
		.cmd            (cmd),
		.sts            (sts),
		.pnt_valid      (points.valid),
		.pnt_data       (points.data),
		.pnt_ready      (points.ready)
	);

endmodule

>>> rtl/hcpe_div.sv
// Restoring divider, one quotient bit per cycle, quotient and remainder held.
// Depends on hcpe_pkg for widths.
module hcpe_div import hcpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> rtl/hcpe_datapath.sv
// Datapath: hit test, column and segment accumulators, step arithmetic,
// the shared divider and the output register. Depends on hcpe_pkg, hcpe_div.
module hcpe_datapath import hcpe_pkg::*; #(
	parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [HUE_W-1:0] target_hue,
	input  logic [LEN_W-1:0] segment_length,
	input  logic [LEN_W-1:0] image_width,
	input  pixel_t           pix,
	input  hcpe_cmd_t        cmd,
	output hcpe_sts_t        sts,
	output logic             pnt_valid,
	output point_t           pnt_data,
	input  logic             pnt_ready
);

	localparam int unsigned COL_W = $clog2(MAX_COLS);
	localparam int unsigned XS_W  = ((COL_W > X_W) ? COL_W : X_W) + 1;
	localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS);
	localparam logic [COL_W:0] COL_LIM = (COL_W+1)'(MAX_COLS);

	logic [SUM_W-1:0]  col_sum_q;
	logic [CNT_W-1:0]  col_cnt_q;
	logic [SUM_W-1:0]  seg_sum_q;
	logic [CNT_W-1:0]  seg_cnt_q;
	logic [COL_W-1:0]  col_ctr_q;
	logic [COL_W-1:0]  seg_start_q;
	logic [STEP_W-1:0] step_q;
	logic [HALF_W-1:0] half_q;
	logic              out_valid_q;
	point_t            out_q;

	logic [LEN_W-1:0]  len;
	logic [PROD_W-1:0] prod;
	logic [STEP_W-1:0] step_raw;
	logic              hit;
	logic [SUM_W:0]    col_sum_inc;
	logic [SUM_W:0]    seg_sum_inc;
	logic [COL_W:0]    ctr_inc;
	logic [XS_W-1:0]   x_sum;
	logic [DIV_W-1:0]  div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [DVS_W-1:0]  div_rem;

	// Segment length and its tenth and twentieth.
	assign len      = (segment_length == '0) ? image_width : segment_length;
	assign prod     = PROD_W'(len) * PROD_W'(RECIP_10);
	assign step_raw = prod[STEP_SHIFT +: STEP_W];

	always_ff @(posedge clk) begin
		step_q <= (step_raw == '0) ? STEP_W'(1) : step_raw;
		half_q <= prod[HALF_SHIFT +: HALF_W];
	end

	// Hue strictly inside the band: tgt-5 < hue < tgt+5, and row index below MAX_ROWS.
	assign hit = ({1'b0, pix.pixel_hue} + HUE_BAND > {1'b0, target_hue})
		&& ({1'b0, pix.pixel_hue} < {1'b0, target_hue} + HUE_BAND)
		&& (17'(pix.row_index) < ROW_LIM);

	assign col_sum_inc = (SUM_W+1)'(col_sum_q) + (SUM_W+1)'(pix.row_index);
	assign seg_sum_inc = (SUM_W+1)'(seg_sum_q) + (SUM_W+1)'(div_quo);
	assign ctr_inc     = (COL_W+1)'(col_ctr_q) + (COL_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_sum_q   <= '0;
			col_cnt_q   <= '0;
			seg_sum_q   <= '0;
			seg_cnt_q   <= '0;
			col_ctr_q   <= '0;
			seg_start_q <= '0;
		end else if (cmd.clear_img) begin
			col_sum_q   <= '0;
			col_cnt_q   <= '0;
			seg_sum_q   <= '0;
			seg_cnt_q   <= '0;
			col_ctr_q   <= '0;
			seg_start_q <= '0;
		end else begin
			if (cmd.accept && hit) begin
				col_sum_q <= col_sum_inc[SUM_W] ? SUM_MAX : col_sum_inc[SUM_W-1:0];
				if (col_cnt_q != CNT_MAX) begin
					col_cnt_q <= col_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.col_close) begin
				col_sum_q <= '0;
				col_cnt_q <= '0;
			end
			if (cmd.col_add) begin
				seg_sum_q <= seg_sum_inc[SUM_W] ? SUM_MAX : seg_sum_inc[SUM_W-1:0];
				if (seg_cnt_q != CNT_MAX) begin
					seg_cnt_q <= seg_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.emit) begin
				seg_start_q <= col_ctr_q;
				seg_sum_q   <= '0;
				seg_cnt_q   <= '0;
			end
			if (cmd.advance) begin
				col_ctr_q <= (ctr_inc >= COL_LIM) ? '0 : ctr_inc[COL_W-1:0];
			end
		end
	end

	// One divider serves the column mean, the step test and the segment mean.
	always_comb begin
		case (cmd.div_sel)
			DSEL_COL: begin
				div_dividend = col_sum_q;
				div_divisor  = col_cnt_q;
			end
			DSEL_MOD: begin
				div_dividend = DIV_W'(col_ctr_q);
				div_divisor  = DVS_W'(step_q);
			end
			default: begin
				div_dividend = seg_sum_q;
				div_divisor  = seg_cnt_q;
			end
		endcase
	end

	hcpe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign x_sum = XS_W'(seg_start_q) + XS_W'(half_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (pnt_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.point_x  <= x_sum[X_W-1:0];
			out_q.point_y  <= (seg_cnt_q != '0) ? div_quo[Y_W-1:0] : '0;
			out_q.has_data <= (seg_cnt_q != '0);
		end
	end

	assign pnt_valid = out_valid_q;
	assign pnt_data  = out_q;

	assign sts.col_hits = (col_cnt_q != '0);
	assign sts.seg_hits = (seg_cnt_q != '0);
	assign sts.col_zero = (col_ctr_q == '0);
	assign sts.div_done = div_done;
	assign sts.rem_zero = (div_rem == '0);
	assign sts.out_free = !out_valid_q || pnt_ready;

endmodule

>>> rtl/hcpe_ctrl.sv
// Controller state machine: pixel handshake and the column-end sequence.
// Depends on hcpe_pkg for the command and status structs.
module hcpe_ctrl import hcpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	input  logic      column_end,
	input  logic      image_end,
	input  hcpe_sts_t sts,
	output logic      pix_ready,
	output hcpe_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_CLOSE   = 8'b0000_0010,
		S_COL_DIV = 8'b0000_0100,
		S_CHECK   = 8'b0000_1000,
		S_MOD_DIV = 8'b0001_0000,
		S_SEG_DIV = 8'b0010_0000,
		S_EMIT    = 8'b0100_0000,
		S_FINISH  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   img_q;

	always_comb begin
		state_d   = state_q;
		pix_ready = 1'b0;
		cmd       = '0;
		cmd.div_sel = DSEL_COL;
		unique case (state_q)
			S_IDLE: begin
				pix_ready  = 1'b1;
				cmd.accept = pix_valid;
				if (pix_valid) begin
					if (column_end) begin
						state_d = S_CLOSE;
					end else begin
						cmd.clear_img = image_end;
					end
				end
			end
			S_CLOSE: begin
				if (sts.col_hits) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_COL;
					state_d       = S_COL_DIV;
				end else begin
					cmd.col_close = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_COL_DIV: begin
				if (sts.div_done) begin
					cmd.col_close = 1'b1;
					cmd.col_add   = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.col_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_MOD;
					state_d       = S_MOD_DIV;
				end
			end
			S_MOD_DIV: begin
				if (sts.div_done) begin
					if (!sts.rem_zero) begin
						state_d = S_FINISH;
					end else if (sts.seg_hits) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DSEL_SEG;
						state_d       = S_SEG_DIV;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_SEG_DIV: begin
				cmd.div_sel = DSEL_SEG;
				if (sts.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.advance   = 1'b1;
				cmd.clear_img = img_q;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			img_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && pix_valid && column_end) begin
				img_q <= image_end;
			end
		end
	end

endmodule
